>>> rtl/core/abg_pkg.sv
// Shared types, constants and saturation helpers for the alpha-beta-gamma tracker.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
`timescale 1ns / 1ps

package abg_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COEF_W     = 48;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned NUM_DIGITS = COEF_W / DIGIT_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS);
  localparam int unsigned ACC_W      = DATA_W + 1;
  localparam int unsigned PP_W       = DATA_W + DIGIT_W + 1;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned NUM_UNITS  = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DT        = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HALF_DT_SQ = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ALPHA     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_BETA      = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_GAMMA     = IDX_W'(4);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [COEF_W-1:0] dt;
    logic [COEF_W-1:0] half_dt_sq;
    logic [COEF_W-1:0] alpha;
    logic [COEF_W-1:0] beta_over_dt;
    logic [COEF_W-1:0] gamma_term;
  } abg_coefs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_RESID,
    ST_CORR,
    ST_WRITE
  } abg_state_e;

  // saturate a sum of up to four 32-bit terms to signed 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > (DATA_W+2)'(S32_MAX)) begin
      r = S32_MAX;
    end else if (x < (DATA_W+2)'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/abg_coef_regs.sv
// Coefficient register file of the alpha-beta-gamma tracker: five 48-bit write-only registers.
// Depends on abg_pkg for the register indexes and the coefficient struct.
`timescale 1ns / 1ps

module abg_coef_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [abg_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [abg_pkg::COEF_W-1:0]  cfg_data_i,
  output abg_pkg::abg_coefs_t         coefs_o
);

  abg_pkg::abg_coefs_t coefs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        abg_pkg::REG_DT:         coefs_q.dt           <= cfg_data_i;
        abg_pkg::REG_HALF_DT_SQ: coefs_q.half_dt_sq   <= cfg_data_i;
        abg_pkg::REG_ALPHA:      coefs_q.alpha        <= cfg_data_i;
        abg_pkg::REG_BETA:       coefs_q.beta_over_dt <= cfg_data_i;
        abg_pkg::REG_GAMMA:      coefs_q.gamma_term   <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign coefs_o = coefs_q;

endmodule

>>> rtl/core/abg_digit_mul.sv
// Digit-serial multiplier: unsigned Q24.24 coefficient times signed Q16.16 value,
// floor-shifted by 24 and saturated to 32 bits. One 8-bit coefficient digit per cycle.
// Depends on abg_pkg for widths and the saturation limits.
`timescale 1ns / 1ps

module abg_digit_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic        [abg_pkg::COEF_W-1:0]  coef_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  x_i,
  output logic                               done_o,
  output logic signed [abg_pkg::DATA_W-1:0]  prod_o
);

  localparam int unsigned HiW = abg_pkg::DATA_W - abg_pkg::FRAC_W;

  logic                                busy_q;
  logic                                done_q;
  logic [abg_pkg::CNT_W-1:0]           cnt_q;
  logic [abg_pkg::COEF_W-1:0]          coef_q;
  logic signed [abg_pkg::DATA_W-1:0]   x_q;
  logic signed [abg_pkg::ACC_W-1:0]    acc_q;
  logic [abg_pkg::FRAC_W-1:0]          low_q;

  logic [abg_pkg::DIGIT_W-1:0]         digit;
  logic signed [abg_pkg::PP_W-1:0]     pp;
  logic signed [abg_pkg::PP_W-1:0]     sum;
  logic                                last;
  logic                                fits;

  assign digit = coef_q[abg_pkg::DIGIT_W-1:0];
  assign pp    = abg_pkg::PP_W'(x_q) * abg_pkg::PP_W'($signed({1'b0, digit}));
  assign sum   = abg_pkg::PP_W'(acc_q) + pp;
  assign last  = (cnt_q == abg_pkg::CNT_W'(abg_pkg::NUM_DIGITS - 1));

  // LSB digit first; the accumulator shifts right so the adder stays narrow.
  // Low bits that leave it are kept only for the last FRAC_W bits of shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (busy_q) begin
        cnt_q <= cnt_q + abg_pkg::CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      coef_q <= coef_i;
      x_q    <= x_i;
      acc_q  <= '0;
      low_q  <= '0;
    end else if (busy_q) begin
      coef_q <= coef_q >> abg_pkg::DIGIT_W;
      acc_q  <= abg_pkg::ACC_W'(sum >>> abg_pkg::DIGIT_W);
      low_q  <= {sum[abg_pkg::DIGIT_W-1:0], low_q[abg_pkg::FRAC_W-1:abg_pkg::DIGIT_W]};
    end
  end

  // Result is {acc, low}; it fits in 32 bits when acc fits in the top HiW bits.
  assign fits = (acc_q[abg_pkg::ACC_W-1:HiW-1] == '0)
             || (acc_q[abg_pkg::ACC_W-1:HiW-1] == '1);

  always_comb begin
    if (fits) begin
      prod_o = {acc_q[HiW-1:0], low_q};
    end else if (acc_q[abg_pkg::ACC_W-1]) begin
      prod_o = abg_pkg::S32_MIN;
    end else begin
      prod_o = abg_pkg::S32_MAX;
    end
  end

  assign done_o = done_q;

endmodule

>>> rtl/core/alpha_beta_gamma_tracker.sv
// Alpha-beta-gamma tracker: top level with the item sequencer and the estimate registers.
// Depends on abg_pkg, abg_coef_regs and abg_digit_mul.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, op_i, measurement_i): op_i low updates the
//   estimates with one Q16.16 position measurement, op_i high clears them to zero.
//   Output channel (out_valid_o / out_stall_i): one item per input item carrying the
//   position, velocity and acceleration estimates after that input item.
//   Configuration port (cfg_we_i, cfg_index_i, cfg_data_i): five Q24.24 coefficients, to be
//   written by the user only while the block is idle; the block does not enforce this.
// Sequencing:
//   An update item makes two passes through three digit-serial multipliers, six 8-bit
//   digits each, then a write step; input stays stalled until the block is back in idle,
//   so an item is taken only once the previous one has been written.
//   A clear item zeroes the estimates on acceptance and goes straight to the write step,
//   after which the block returns to idle and takes the next item.
// Reset: coefficients and all estimates are zero, no result is pending.
// Stall: the finished result sits in an output register; the block holds the next result
//   in its write step until the output register is taken, and stalls input meanwhile.
`timescale 1ns / 1ps

module alpha_beta_gamma_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               op_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  measurement_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [abg_pkg::DATA_W-1:0]  position_est_o,
  output logic signed [abg_pkg::DATA_W-1:0]  velocity_est_o,
  output logic signed [abg_pkg::DATA_W-1:0]  accel_est_o,
  input  logic                               cfg_we_i,
  input  logic [abg_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [abg_pkg::COEF_W-1:0]         cfg_data_i
);

  localparam int unsigned SumW = abg_pkg::DATA_W + 2;

  abg_pkg::abg_coefs_t coefs;
  abg_pkg::abg_state_e state_q, state_d;

  logic signed [abg_pkg::DATA_W-1:0] pos_q, vel_q, acc_q;
  logic signed [abg_pkg::DATA_W-1:0] ppred_q, vpred_q, meas_q;
  logic                              out_valid_q;
  logic signed [abg_pkg::DATA_W-1:0] out_pos_q, out_vel_q, out_acc_q;

  logic                              in_accept;
  logic                              mul_start;
  logic                              phase_b;
  logic                              clear_en, pred_en, corr_en, out_load;
  logic signed [abg_pkg::DATA_W-1:0] resid;
  logic [abg_pkg::COEF_W-1:0]        mul_coef [abg_pkg::NUM_UNITS];
  logic signed [abg_pkg::DATA_W-1:0] mul_x    [abg_pkg::NUM_UNITS];
  logic signed [abg_pkg::DATA_W-1:0] mul_prod [abg_pkg::NUM_UNITS];
  logic [abg_pkg::NUM_UNITS-1:0]     mul_done;

  abg_coef_regs u_coef_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coefs_o     (coefs)
  );

  assign in_stall_o = (state_q != abg_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign phase_b    = (state_q == abg_pkg::ST_RESID);

  assign resid = abg_pkg::sat32(SumW'(meas_q) - SumW'(ppred_q));

  // First pass forms the prediction products, second pass the corrections.
  always_comb begin
    if (phase_b) begin
      mul_coef[0] = coefs.alpha;
      mul_coef[1] = coefs.beta_over_dt;
      mul_coef[2] = coefs.gamma_term;
      mul_x[0]    = resid;
      mul_x[1]    = resid;
      mul_x[2]    = resid;
    end else begin
      mul_coef[0] = coefs.dt;
      mul_coef[1] = coefs.half_dt_sq;
      mul_coef[2] = coefs.dt;
      mul_x[0]    = vel_q;
      mul_x[1]    = acc_q;
      mul_x[2]    = acc_q;
    end
  end

  for (genvar g = 0; g < abg_pkg::NUM_UNITS; g++) begin : g_mul
    abg_digit_mul u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (mul_start),
      .coef_i  (mul_coef[g]),
      .x_i     (mul_x[g]),
      .done_o  (mul_done[g]),
      .prod_o  (mul_prod[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    clear_en  = 1'b0;
    pred_en   = 1'b0;
    corr_en   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      abg_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (op_i == abg_pkg::OP_CLEAR) begin
            clear_en = 1'b1;
            state_d  = abg_pkg::ST_WRITE;
          end else begin
            mul_start = 1'b1;
            state_d   = abg_pkg::ST_PRED;
          end
        end
      end
      abg_pkg::ST_PRED: begin
        if (mul_done[0]) begin
          pred_en = 1'b1;
          state_d = abg_pkg::ST_RESID;
        end
      end
      abg_pkg::ST_RESID: begin
        mul_start = 1'b1;
        state_d   = abg_pkg::ST_CORR;
      end
      abg_pkg::ST_CORR: begin
        if (mul_done[0]) begin
          corr_en = 1'b1;
          state_d = abg_pkg::ST_WRITE;
        end
      end
      abg_pkg::ST_WRITE: begin
        // hold until the output register is free or being taken
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = abg_pkg::ST_IDLE;
        end
      end
      default: state_d = abg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
      acc_q <= '0;
    end else if (clear_en) begin
      pos_q <= '0;
      vel_q <= '0;
      acc_q <= '0;
    end else if (corr_en) begin
      pos_q <= abg_pkg::sat32(SumW'(ppred_q) + SumW'(mul_prod[0]));
      vel_q <= abg_pkg::sat32(SumW'(vpred_q) + SumW'(mul_prod[1]));
      acc_q <= abg_pkg::sat32(SumW'(acc_q) + SumW'(mul_prod[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      meas_q <= measurement_i;
    end
    if (pred_en) begin
      ppred_q <= abg_pkg::sat32(SumW'(pos_q) + SumW'(mul_prod[0]) + SumW'(mul_prod[1]));
      vpred_q <= abg_pkg::sat32(SumW'(vel_q) + SumW'(mul_prod[2]));
    end
    if (out_load) begin
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_acc_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_est_o = out_pos_q;
  assign velocity_est_o = out_vel_q;
  assign accel_est_o    = out_acc_q;

  // a clear item leaves all three estimates at zero
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op_i == abg_pkg::OP_CLEAR) |=> (pos_q == '0 && vel_q == '0 && acc_q == '0))
    else $error("estimates not zero after clear item");

  // the three multipliers always finish together and only while the sequencer waits on them
  a_mul_done_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_done[0] |-> (mul_done == '1
                      && (state_q == abg_pkg::ST_PRED || state_q == abg_pkg::ST_CORR))))
    else $error("multiplier done out of step with sequencer");

  // a new result enters the output register only from the write step
  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == abg_pkg::ST_WRITE)
    else $error("output valid raised outside write step");

  // no item is taken while the multipliers are busy
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abg_pkg::ST_PRED || state_q == abg_pkg::ST_CORR) |-> !in_accept)
    else $error("item accepted during multiply pass");

endmodule

>>> sim/abg_tracker_checker.sv
// Checker for the alpha-beta-gamma tracker: watches the item channels and the coefficient port,
// predicts each result in fixed point and compares it with the block's output.
// Depends on abg_pkg.
`timescale 1ns / 1ps

module abg_tracker_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic                               op_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  measurement_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  position_est_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  velocity_est_i,
  input  logic signed [abg_pkg::DATA_W-1:0]  accel_est_i,
  input  logic                               cfg_we_i,
  input  logic [abg_pkg::IDX_W-1:0]          cfg_index_i,
  input  logic [abg_pkg::COEF_W-1:0]         cfg_data_i,
  output int                                 error_count_o,
  output int                                 pending_o
);

  import abg_pkg::*;

  typedef logic signed [DATA_W-1:0] q16_t;
  // wide enough for a 49-bit signed coefficient times a 32-bit value, exactly
  typedef logic signed [DATA_W+COEF_W:0] wide_t;

  typedef struct packed {
    q16_t position;
    q16_t velocity;
    q16_t accel;
  } estimate_t;

  localparam wide_t Q16_MAX = wide_t'(S32_MAX);
  localparam wide_t Q16_MIN = wide_t'(S32_MIN);

  abg_coefs_t coefs;
  q16_t       pos_s;
  q16_t       vel_s;
  q16_t       acc_s;
  estimate_t  pending_estimates[$];
  int         mismatches;

  assign error_count_o = mismatches;

  function automatic q16_t clamp_s32(wide_t x);
    if (x > Q16_MAX) begin
      return S32_MAX;
    end
    if (x < Q16_MIN) begin
      return S32_MIN;
    end
    return x[DATA_W-1:0];
  endfunction

  // floor(coef * x / 2^24), saturated
  function automatic q16_t coef_product(logic [COEF_W-1:0] c, q16_t x);
    wide_t prod;
    prod = $signed({1'b0, c}) * x;
    return clamp_s32(prod >>> FRAC_W);
  endfunction

  function automatic estimate_t next_estimate(logic op, q16_t meas);
    q16_t      ppred;
    q16_t      vpred;
    q16_t      resid;
    estimate_t e;
    if (op == OP_CLEAR) begin
      e = '0;
    end else begin
      ppred = clamp_s32(wide_t'(pos_s) + wide_t'(coef_product(coefs.dt, vel_s))
                        + wide_t'(coef_product(coefs.half_dt_sq, acc_s)));
      vpred = clamp_s32(wide_t'(vel_s) + wide_t'(coef_product(coefs.dt, acc_s)));
      resid = clamp_s32(wide_t'(meas) - wide_t'(ppred));
      e.position = clamp_s32(wide_t'(ppred) + wide_t'(coef_product(coefs.alpha, resid)));
      e.velocity = clamp_s32(wide_t'(vpred) + wide_t'(coef_product(coefs.beta_over_dt, resid)));
      e.accel    = clamp_s32(wide_t'(acc_s) + wide_t'(coef_product(coefs.gamma_term, resid)));
    end
    return e;
  endfunction

  task automatic check_field(string field, q16_t want, q16_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d (%h), actual %0d (%h)",
               $time, field, want, want, got, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    estimate_t want;
    if (!rst_ni) begin
      coefs      <= '0;
      pos_s      <= '0;
      vel_s      <= '0;
      acc_s      <= '0;
      pending_o  <= 0;
      mismatches = 0;
      pending_estimates.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DT:         coefs.dt           <= cfg_data_i;
          REG_HALF_DT_SQ: coefs.half_dt_sq   <= cfg_data_i;
          REG_ALPHA:      coefs.alpha        <= cfg_data_i;
          REG_BETA:       coefs.beta_over_dt <= cfg_data_i;
          REG_GAMMA:      coefs.gamma_term   <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: result with no item outstanding: expected none, actual %h %h %h",
                   $time, position_est_i, velocity_est_i, accel_est_i);
          mismatches++;
        end else begin
          want = pending_estimates.pop_front();
          check_field("position_est", want.position, position_est_i);
          check_field("velocity_est", want.velocity, velocity_est_i);
          check_field("accel_est", want.accel, accel_est_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = next_estimate(op_i, measurement_i);
        pos_s <= want.position;
        vel_s <= want.velocity;
        acc_s <= want.accel;
        pending_estimates.push_back(want);
      end
      pending_o <= pending_estimates.size();
    end
  end

endmodule

>>> sim/tb_alpha_beta_gamma_tracker.sv
// Top of the tracker testbench: clock, reset, coefficient writes, item stimulus and verdict.
// Depends on abg_pkg, alpha_beta_gamma_tracker and abg_tracker_checker.
`timescale 1ns / 1ps

module tb_alpha_beta_gamma_tracker;

  import abg_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 14;
  localparam int PHASE_ITEMS  = 100;

  localparam logic [COEF_W-1:0] ONE_Q24  = COEF_W'(1) << FRAC_W;
  localparam logic [COEF_W-1:0] HALF_Q24 = COEF_W'(1) << (FRAC_W - 1);

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     op_i;
  logic signed [DATA_W-1:0] measurement_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] position_est_o;
  logic signed [DATA_W-1:0] velocity_est_o;
  logic signed [DATA_W-1:0] accel_est_o;
  logic                     cfg_we_i;
  logic [IDX_W-1:0]         cfg_index_i;
  logic [COEF_W-1:0]        cfg_data_i;

  int error_count;
  int pending;
  int cycles      = 0;
  int stall_left  = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  bit rx_idle     = 1'b0;
  bit tx_gaps     = 1'b0;

  alpha_beta_gamma_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .measurement_i  (measurement_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_est_o (position_est_o),
    .velocity_est_o (velocity_est_o),
    .accel_est_o    (accel_est_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  abg_tracker_checker estimate_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .measurement_i  (measurement_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_est_i (position_est_o),
    .velocity_est_i (velocity_est_o),
    .accel_est_i    (accel_est_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .error_count_o  (error_count),
    .pending_o      (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stall bursts, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (hold_ticket != hold_served) begin
      out_stall_i <= 1'b1;
      stall_left  <= HOLD_CYCLES - 1;
      hold_served <= hold_ticket;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic offer(logic op, logic signed [DATA_W-1:0] meas);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    measurement_i <= meas;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_coef(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic load_coefs(abg_coefs_t c);
    write_coef(REG_DT, c.dt);
    write_coef(REG_HALF_DT_SQ, c.half_dt_sq);
    write_coef(REG_ALPHA, c.alpha);
    write_coef(REG_BETA, c.beta_over_dt);
    write_coef(REG_GAMMA, c.gamma_term);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] bend_coef(logic [COEF_W-1:0] v);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return COEF_W'({$urandom, $urandom});
      default: return v;
    endcase
  endfunction

  function automatic abg_coefs_t pick_coefs();
    abg_coefs_t        c;
    logic [COEF_W-1:0] d;
    int                mode;
    mode           = $urandom_range(0, 9);
    d              = COEF_W'($urandom_range(1 << 16, 1 << 24));
    c.dt           = d;
    c.half_dt_sq   = COEF_W'((longint'(d) * longint'(d)) >> (FRAC_W + 1));
    c.alpha        = COEF_W'($urandom_range(0, 1 << 24));
    c.beta_over_dt = COEF_W'($urandom_range(0, 1 << 24));
    c.gamma_term   = COEF_W'($urandom_range(0, 1 << 22));
    case (mode)
      0: c = '0;
      1: c = '1;
      2, 3: begin
        c.dt           = bend_coef(c.dt);
        c.half_dt_sq   = bend_coef(c.half_dt_sq);
        c.alpha        = bend_coef(c.alpha);
        c.beta_over_dt = bend_coef(c.beta_over_dt);
        c.gamma_term   = bend_coef(c.gamma_term);
      end
      default: ;
    endcase
    return c;
  endfunction

  // mostly a smooth track with noise; now and then a wild value or an extreme
  function automatic logic signed [DATA_W-1:0] track_point(int base, int slope, int bend, int k);
    case ($urandom_range(0, 15))
      0:       return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0:       return S32_MAX;
          1:       return S32_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return base + slope * k + bend * k * k + int'($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  initial begin
    abg_coefs_t c;
    int         base;
    int         slope;
    int         bend;

    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    op_i          <= OP_UPDATE;
    measurement_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_DT;
    cfg_data_i    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients still at reset: every estimate stays zero
    offer(OP_UPDATE, S32_MAX);
    offer(OP_UPDATE, S32_MIN);
    settle();

    // writes past the last register must leave the coefficients alone
    for (int i = REG_GAMMA + 1; i < (1 << IDX_W); i++) begin
      write_coef(IDX_W'(i), '1);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    offer(OP_UPDATE, 32'sh0003_0000);
    settle();

    c.dt           = ONE_Q24;
    c.half_dt_sq   = HALF_Q24;
    c.alpha        = HALF_Q24;
    c.beta_over_dt = ONE_Q24 >> 2;
    c.gamma_term   = ONE_Q24 >> 4;
    load_coefs(c);
    offer(OP_UPDATE, '0);
    offer(OP_UPDATE, 32'sd1);
    offer(OP_UPDATE, '1);
    offer(OP_UPDATE, 32'sh0001_0000);
    repeat (3) offer(OP_UPDATE, S32_MAX);
    repeat (3) offer(OP_UPDATE, S32_MIN);
    offer(OP_CLEAR, S32_MAX);
    offer(OP_UPDATE, 32'sh0001_0000);
    offer(OP_CLEAR, '0);
    offer(OP_CLEAR, '1);
    settle();

    load_coefs('1);
    offer(OP_UPDATE, S32_MAX);
    offer(OP_UPDATE, S32_MIN);
    offer(OP_UPDATE, S32_MAX);
    offer(OP_CLEAR, '0);
    offer(OP_UPDATE, '1);
    settle();

    // hold off the result side while items keep coming, so the block backs up
    c.dt           = ONE_Q24 >> 3;
    c.half_dt_sq   = ONE_Q24 >> 7;
    c.alpha        = HALF_Q24;
    c.beta_over_dt = ONE_Q24;
    c.gamma_term   = ONE_Q24 >> 2;
    load_coefs(c);
    hold_ticket <= hold_ticket + 1;
    for (int k = 0; k < 24; k++) begin
      offer(OP_UPDATE, 32'sh0000_4000 * k);
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      load_coefs(pick_coefs());
      tx_gaps = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle <= (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      base  = int'($urandom_range(0, 1 << 24)) - (1 << 23);
      slope = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      bend  = int'($urandom_range(0, 64)) - 32;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 31) == 0) begin
          offer(OP_CLEAR, $urandom);
        end else begin
          offer(OP_UPDATE, track_point(base, slope, bend, k));
        end
        if (ph < PHASES - 1 && $urandom_range(0, 199) == 0) begin
          settle();
        end
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/abg_pkg.sv
rtl/core/abg_coef_regs.sv
rtl/core/abg_digit_mul.sv
rtl/core/alpha_beta_gamma_tracker.sv
sim/abg_tracker_checker.sv
sim/tb_alpha_beta_gamma_tracker.sv
